FILE: rtl/sba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sba_pkg
// Shared types and constants for the stack arithmetic unit.
// ----------------------------------------------------------------------------
package sba_pkg;

  localparam int STACK_DEPTH_DEF = 64;
  localparam int WORD_WIDTH_DEF  = 32;

  // beat field widths
  localparam int ACTION_W   = 3;
  localparam int PUSH_W     = 32;
  localparam int STATUS_W   = 2;
  localparam int TOP_W      = 32;
  localparam int DEPTH_W    = 7;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH = 3'd0,
    ACT_ADD  = 3'd1,
    ACT_SUB  = 3'd2,
    ACT_MUL  = 3'd3,
    ACT_DIV  = 3'd4,
    ACT_MOD  = 3'd5
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK    = 2'd0,
    STS_SHORT = 2'd1,
    STS_DIVZ  = 2'd2,
    STS_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_READ = 2'd1,
    S_CALC = 2'd2,
    S_DONE = 2'd3
  } sba_state_t;

  typedef enum logic [1:0] {
    MDU_MUL = 2'd0,
    MDU_DIV = 2'd1,
    MDU_MOD = 2'd2
  } mdu_op_t;

  typedef struct packed {
    logic    start;
    mdu_op_t op;
  } mdu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mdu_rsp_t;

endpackage

FILE: rtl/sba_stack_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sba_stack_ram
// Stack storage: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module sba_stack_ram #(
  parameter int DEPTH = sba_pkg::STACK_DEPTH_DEF,
  parameter int WIDTH = sba_pkg::WORD_WIDTH_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

FILE: rtl/sba_muldiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sba_muldiv
// Iterative radix-2 unit: shift-add multiply and restoring signed divide,
// one bit per cycle.
// ----------------------------------------------------------------------------
module sba_muldiv #(
  parameter int WIDTH = sba_pkg::WORD_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  sba_pkg::mdu_req_t req,
  input  logic [WIDTH-1:0]  a,
  input  logic [WIDTH-1:0]  b,
  output sba_pkg::mdu_rsp_t rsp,
  output logic [WIDTH-1:0]  result
);

  localparam int CNTW = $clog2(WIDTH);

  logic              busy;
  logic              done;
  sba_pkg::mdu_op_t  op;
  logic [CNTW-1:0]   cnt;
  logic [WIDTH-1:0]  acc;
  logic [WIDTH-1:0]  opa;
  logic [WIDTH-1:0]  opb;
  logic [WIDTH:0]    rem;
  logic              neg_q;
  logic              neg_r;

  logic [WIDTH-1:0]  a_mag;
  logic [WIDTH-1:0]  b_mag;
  logic [WIDTH:0]    rem_sh;
  logic [WIDTH:0]    diff;

  assign a_mag  = a[WIDTH-1] ? WIDTH'('0 - a) : a;
  assign b_mag  = b[WIDTH-1] ? WIDTH'('0 - b) : b;
  assign rem_sh = {rem[WIDTH-1:0], opa[WIDTH-1]};
  assign diff   = rem_sh - {1'b0, opb};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op  <= req.op;
      cnt <= CNTW'(WIDTH - 1);
      acc <= '0;
      rem <= '0;
      if (req.op == sba_pkg::MDU_MUL) begin
        opa <= a;
        opb <= b;
      end else begin
        opa <= a_mag;
        opb <= b_mag;
      end
      neg_q <= a[WIDTH-1] ^ b[WIDTH-1];
      neg_r <= a[WIDTH-1];
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (op == sba_pkg::MDU_MUL) begin
        if (opb[0]) begin
          acc <= acc + opa;
        end
        opa <= {opa[WIDTH-2:0], 1'b0};
        opb <= {1'b0, opb[WIDTH-1:1]};
      end else begin
        // restoring step: quotient bits shift into opa from the bottom
        if (!diff[WIDTH]) begin
          rem <= diff;
          opa <= {opa[WIDTH-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          opa <= {opa[WIDTH-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    case (op)
      sba_pkg::MDU_MUL: result = acc;
      sba_pkg::MDU_DIV: result = neg_q ? WIDTH'('0 - opa) : opa;
      sba_pkg::MDU_MOD: result = neg_r ? WIDTH'('0 - rem[WIDTH-1:0]) : rem[WIDTH-1:0];
      default:          result = acc;
    endcase
  end

  assign rsp.busy = busy;
  assign rsp.done = done;

endmodule

FILE: rtl/stack_binary_arithmetic_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_binary_arithmetic_top
// Bounded stack of signed words with push and binary arithmetic actions.
// Sequence: S_IDLE takes the input beat; S_READ reads the stack and finishes
//   push, add, subtract, ignored actions and errors; multiply, divide and modulo
//   wait in S_CALC for the one-bit-per-cycle multiply/divide unit; S_DONE loads the output register.
// Throughput: one item at a time; a new beat is taken as soon as the previous
//   result sits in the output register, which can wait on m_tready.
// Reset: synchronous; empties the stack and drops any pending output beat.
// ----------------------------------------------------------------------------
module stack_binary_arithmetic_top #(
  parameter int STACK_DEPTH = sba_pkg::STACK_DEPTH_DEF,
  parameter int WORD_WIDTH  = sba_pkg::WORD_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [2:0] action, [34:3] push_value, [39:35] zero
  input  logic [sba_pkg::IN_DATA_W-1:0]  s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [1:0] status, [33:2] top_value, [40:34] depth, [47:41] zero
  output logic [sba_pkg::OUT_DATA_W-1:0] m_tdata
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  sba_pkg::sba_state_t state, state_next;
  logic [CW-1:0]         count, count_next;
  sba_pkg::status_t      res_status, res_status_next;
  logic [WORD_WIDTH-1:0] res_top, res_top_next;
  sba_pkg::action_t      act;
  logic [WORD_WIDTH-1:0] push_word;

  logic                  s_accept;
  logic                  out_load;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [WORD_WIDTH-1:0] mem_wdata;
  logic [WORD_WIDTH-1:0] rd_top;
  logic [WORD_WIDTH-1:0] rd_second;
  logic                  has_top;
  logic [WORD_WIDTH-1:0] sum;
  logic [WORD_WIDTH-1:0] dif;

  sba_pkg::mdu_req_t     mdu_req;
  sba_pkg::mdu_rsp_t     mdu_rsp;
  logic [WORD_WIDTH-1:0] mdu_result;

  assign s_tready = (state == sba_pkg::S_IDLE);
  assign s_accept = s_tvalid && s_tready;

  sba_stack_ram #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (WORD_WIDTH)
  ) u_ram (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (s_accept),
    .raddr_a (AW'(count - CW'(1))),
    .raddr_b (AW'(count - CW'(2))),
    .rdata_a (rd_top),
    .rdata_b (rd_second)
  );

  sba_muldiv #(
    .WIDTH (WORD_WIDTH)
  ) u_muldiv (
    .clk    (clk),
    .rst    (rst),
    .req    (mdu_req),
    .a      (rd_second),
    .b      (rd_top),
    .rsp    (mdu_rsp),
    .result (mdu_result)
  );

  // item capture
  always_ff @(posedge clk) begin
    if (s_accept) begin
      act       <= sba_pkg::action_t'(s_tdata[2:0]);
      push_word <= WORD_WIDTH'($signed(s_tdata[34:3]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sba_pkg::S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    res_status <= res_status_next;
    res_top    <= res_top_next;
  end

  assign has_top = (count != '0);
  assign sum     = rd_second + rd_top;
  assign dif     = rd_second - rd_top;

  always_comb begin
    state_next      = state;
    count_next      = count;
    res_status_next = res_status;
    res_top_next    = res_top;
    mem_we          = 1'b0;
    mem_waddr       = AW'(count);
    mem_wdata       = push_word;
    mdu_req.start   = 1'b0;
    mdu_req.op      = sba_pkg::MDU_MUL;
    out_load        = 1'b0;

    case (state)
      sba_pkg::S_IDLE: begin
        if (s_accept) begin
          state_next = sba_pkg::S_READ;
        end
      end
      sba_pkg::S_READ: begin
        state_next      = sba_pkg::S_DONE;
        res_status_next = sba_pkg::STS_OK;
        res_top_next    = has_top ? rd_top : '0;
        case (act)
          sba_pkg::ACT_PUSH: begin
            if (count == CW'(STACK_DEPTH)) begin
              res_status_next = sba_pkg::STS_FULL;
            end else begin
              mem_we       = 1'b1;
              count_next   = count + 1'b1;
              res_top_next = push_word;
            end
          end
          sba_pkg::ACT_ADD, sba_pkg::ACT_SUB, sba_pkg::ACT_MUL,
          sba_pkg::ACT_DIV, sba_pkg::ACT_MOD: begin
            mem_waddr = AW'(count - CW'(2));
            if (count < CW'(2)) begin
              res_status_next = sba_pkg::STS_SHORT;
            end else if ((act == sba_pkg::ACT_DIV || act == sba_pkg::ACT_MOD)
                         && rd_top == '0) begin
              res_status_next = sba_pkg::STS_DIVZ;
            end else if (act == sba_pkg::ACT_ADD || act == sba_pkg::ACT_SUB) begin
              mem_we       = 1'b1;
              mem_wdata    = (act == sba_pkg::ACT_ADD) ? sum : dif;
              count_next   = count - 1'b1;
              res_top_next = mem_wdata;
            end else begin
              mdu_req.start = 1'b1;
              case (act)
                sba_pkg::ACT_DIV: mdu_req.op = sba_pkg::MDU_DIV;
                sba_pkg::ACT_MOD: mdu_req.op = sba_pkg::MDU_MOD;
                default:          mdu_req.op = sba_pkg::MDU_MUL;
              endcase
              state_next = sba_pkg::S_CALC;
            end
          end
          default: begin
            // unused action codes leave the stack alone
          end
        endcase
      end
      sba_pkg::S_CALC: begin
        mem_waddr = AW'(count - CW'(2));
        mem_wdata = mdu_result;
        if (mdu_rsp.done) begin
          mem_we       = 1'b1;
          count_next   = count - 1'b1;
          res_top_next = mdu_result;
          state_next   = sba_pkg::S_DONE;
        end
      end
      sba_pkg::S_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = sba_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = sba_pkg::S_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {7'b0, sba_pkg::DEPTH_W'(count), sba_pkg::TOP_W'(res_top), res_status};
    end
  end

endmodule

FILE: rtl/sba_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sba_checker
// Port-level checks for the stack arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
module sba_checker #(
  parameter int STACK_DEPTH = sba_pkg::STACK_DEPTH_DEF
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic [sba_pkg::IN_DATA_W-1:0]  s_tdata,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [sba_pkg::OUT_DATA_W-1:0] m_tdata
);

  logic       in_beat;
  logic       out_beat;
  logic [1:0] inflight;

  assign in_beat  = s_tvalid && s_tready;
  assign out_beat = m_tvalid && m_tready;

  // items taken but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else if (in_beat && !out_beat) begin
      inflight <= inflight + 1'b1;
    end else if (out_beat && !in_beat) begin
      inflight <= inflight - 1'b1;
    end
  end

  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output beat shown right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output beat changed");

  a_no_extra_beat: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid |-> inflight != 2'd0) and (in_beat |-> inflight < 2'd2))
    else $error("output beats out of step with input beats");

  a_depth_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[40:34] <= 7'(STACK_DEPTH))
                 && (m_tdata[40:34] != 7'd0 || m_tdata[33:2] == 32'd0)
                 && (s_tdata == s_tdata))
    else $error("depth beyond stack size or non-zero top on empty stack");

endmodule

bind stack_binary_arithmetic_top sba_checker #(
  .STACK_DEPTH (STACK_DEPTH)
) u_sba_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the stack arithmetic unit. A scoreboard keeps its
// own copy of the stack and works out the status, top word and depth that
// each accepted action should produce. Directed corner cases come first:
// short stack, divide by zero, wrap-around and the most negative word over
// minus one. Random phases follow that fill the stack past full, drain it
// below two entries, or mix pushes and operations. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  import sba_pkg::*;

  localparam int          HALF_PERIOD = 10;
  localparam int          NUM_ITEMS   = 450;
  localparam int          MAX_CYCLES  = 400000;
  localparam int          DRAIN_WAIT  = 60;
  localparam int          DEPTH_MAX   = STACK_DEPTH_DEF;
  // spare action codes, which the unit ignores
  localparam logic [2:0]  ACT_SPARE_LO = 3'd6;
  localparam logic [2:0]  ACT_SPARE_HI = 3'd7;
  localparam logic [31:0] WORD_MIN     = 32'h8000_0000;
  localparam logic [31:0] WORD_MAX     = 32'h7fff_ffff;
  localparam logic [31:0] WORD_NEG1    = 32'hffff_ffff;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  bit quiet = 1'b0;
  int cycles = 0;
  int rx_stall = 0;

  typedef struct {
    status_t     status;
    logic [31:0] top;
    logic [6:0]  depth;
  } stack_reply_t;

  class sba_scoreboard;
    logic [31:0]  words [DEPTH_MAX];
    int           fill = 0;
    stack_reply_t replies [$];
    int           mismatches = 0;

    task report(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    function void note_beat(logic [2:0] code, logic [31:0] value);
      stack_reply_t      r;
      logic signed [63:0] a;
      logic signed [63:0] b;
      logic signed [63:0] q;
      r.status = STS_OK;
      case (code)
        ACT_PUSH: begin
          if (fill >= DEPTH_MAX) begin
            r.status = STS_FULL;
          end else begin
            words[fill] = value;
            fill++;
          end
        end
        ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_MOD: begin
          if (fill < 2) begin
            r.status = STS_SHORT;
          end else begin
            // widen to 64 bits so the most negative word over -1 cannot trap
            a = {{32{words[fill-2][31]}}, words[fill-2]};
            b = {{32{words[fill-1][31]}}, words[fill-1]};
            if ((code == ACT_DIV || code == ACT_MOD) && b == 0) begin
              r.status = STS_DIVZ;
            end else begin
              case (code)
                ACT_ADD: q = a + b;
                ACT_SUB: q = a - b;
                ACT_MUL: q = a * b;
                ACT_DIV: q = a / b;
                default: q = a % b;
              endcase
              words[fill-2] = q[31:0];
              fill--;
            end
          end
        end
        default: ;
      endcase
      r.top   = (fill > 0) ? words[fill-1] : '0;
      r.depth = 7'(fill);
      replies.push_back(r);
    endfunction

    task check_beat(logic [OUT_DATA_W-1:0] data);
      stack_reply_t want;
      if (replies.size() == 0) begin
        report($sformatf("beat %h with nothing pending", data));
        return;
      end
      want = replies.pop_front();
      if (data[1:0] !== want.status)
        report($sformatf("status %0d, want %0d", data[1:0], want.status));
      if (data[33:2] !== want.top)
        report($sformatf("top %h, want %h", data[33:2], want.top));
      if (data[40:34] !== want.depth)
        report($sformatf("depth %0d, want %0d", data[40:34], want.depth));
    endtask
  endclass

  sba_scoreboard sb = new();

  stack_binary_arithmetic_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= MAX_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_len(bit may_skip);
    int r;
    r = $urandom_range(0, 99);
    if (may_skip && r < 60) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (rx_stall > 0) begin
      rx_stall <= rx_stall - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (!quiet && $urandom_range(0, 99) < 15) rx_stall <= idle_len(1'b0);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_beat(m_tdata);
  end

  // valid stays high across back-to-back beats; it only drops before a gap
  task send(logic [2:0] code, logic [31:0] value);
    int gap;
    gap = quiet ? 0 : idle_len(1'b1);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, value, code};
    do @(posedge clk); while (!s_tready);
    sb.note_beat(code, value);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 32'd1;
      2:       return WORD_NEG1;
      3:       return WORD_MIN;
      4:       return WORD_MAX;
      5:       return 32'($signed($urandom_range(0, 20)) - 10);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] pick_op();
    int r;
    r = $urandom_range(0, 49);
    if (r == 0) return ACT_SPARE_LO;
    if (r == 1) return ACT_SPARE_HI;
    case (r % 5)
      0:       return ACT_ADD;
      1:       return ACT_SUB;
      2:       return ACT_MUL;
      3:       return ACT_DIV;
      default: return ACT_MOD;
    endcase
  endfunction

  initial begin
    int sent;
    int pct;
    int len;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // corner cases
    send(ACT_ADD, 32'd5);
    send(ACT_PUSH, WORD_MAX);
    send(ACT_MUL, '0);
    send(ACT_PUSH, 32'd1);
    send(ACT_ADD, '0);
    send(ACT_PUSH, WORD_NEG1);
    send(ACT_DIV, '0);
    send(ACT_PUSH, WORD_NEG1);
    send(ACT_MOD, '0);
    send(ACT_PUSH, '0);
    send(ACT_DIV, '0);
    send(ACT_MOD, '0);
    send(ACT_SUB, WORD_NEG1);
    send(ACT_PUSH, -32'sd7);
    send(ACT_PUSH, 32'd2);
    send(ACT_DIV, '0);
    send(ACT_PUSH, 32'd2);
    send(ACT_MOD, '0);
    send(ACT_PUSH, 32'h1234_5678);
    send(ACT_MUL, '0);
    send(ACT_SPARE_LO, WORD_NEG1);
    send(ACT_SPARE_HI, '0);

    sent = 0;
    while (sent < NUM_ITEMS) begin
      quiet = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 5))
        0: begin
          // fill up, then push onto a full stack
          while (sb.fill < DEPTH_MAX) begin
            send(ACT_PUSH, pick_word());
            sent++;
          end
          repeat ($urandom_range(1, 3)) begin
            send(ACT_PUSH, pick_word());
            sent++;
          end
        end
        1: begin
          // drain below two entries, then two operations on the short stack
          while (sb.fill >= 2) begin
            send(pick_op(), $urandom);
            sent++;
          end
          repeat (2) begin
            send(pick_op(), $urandom);
            sent++;
          end
        end
        default: begin
          pct = 30 + 20 * $urandom_range(0, 2);
          len = $urandom_range(10, 60);
          repeat (len) begin
            if ($urandom_range(0, 99) < pct) send(ACT_PUSH, pick_word());
            else send(pick_op(), $urandom);
            sent++;
          end
        end
      endcase
    end

    quiet = 1'b0;
    @(posedge clk);
    s_tvalid <= 1'b0;
    while (sb.replies.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
